FILE: design/lmx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lmx_pkg;

  // Pixel response, signed Q16.16
  typedef logic signed [31:0] pix_t;

  // One line store entry: the two previous lines at a column
  typedef struct packed {
    pix_t older;
    pix_t newer;
  } line_pair_t;

  // Frame geometry registers
  localparam int CNT_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_COUNT = 2'd1;

  // Result index width
  localparam int IDX_W = 10;

  // 3x3 window
  localparam int WIN_N   = 9;
  localparam int WIN_CTR = 4;

endpackage

`default_nettype wire

FILE: design/local_max_3x3_detector.sv
// 3x3 local maximum detector (non-maximum suppression) over a streamed frame.
// Input channel: in_response / in_is_pad with in_valid and in_stall; pixels
// come in scan order, line index slow, pixel index fast. After each frame the
// host sends inner_count+1 more items to drain the last line.
// Result channel: out_* fields with out_valid and out_stall. One result per
// peak pixel (no in-frame neighbor strictly greater) and one for the frame's
// final pixel, flagged by out_frame_end.
// Throughput: one item per clock while the result channel is not stalled. A pixel
// is decided one line plus one item after it arrives. The line store read lands
// with the stage 1 capture of the deciding item; the window shift and compare
// then load its result into the output register when stage 1 advances.
// The line store is a single-port-read, single-port-write memory holding both
// previous lines per column; a read that hits the column being written in the
// same cycle takes the write data.
// Configuration: cfg_we with cfg_index / cfg_wdata sets outer_count or
// inner_count and restarts the frame; write only while the block is idle.
// Reset: synchronous, active low; counts return to 640 x 480 (clamped to the
// parameters), the position and window clear. Line stores are not cleared.
// Stall: a stalled result holds in the output register; one more item can
// complete behind it, then in_stall rises until out_stall drops.
`timescale 1ns / 1ps
`default_nettype none

module local_max_3x3_detector #(
  parameter int MAX_INNER = 1024,
  parameter int MAX_OUTER = 1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // configuration
  input  wire logic                            cfg_we,
  input  wire logic [lmx_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lmx_pkg::CNT_W-1:0]       cfg_wdata,
  // input channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire lmx_pkg::pix_t                   in_response,
  input  wire logic                            in_is_pad,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [lmx_pkg::IDX_W-1:0]            out_outer_index,
  output logic [lmx_pkg::IDX_W-1:0]            out_inner_index,
  output lmx_pkg::pix_t                        out_value,
  output logic                                 out_is_peak,
  output logic                                 out_frame_end
);
  import lmx_pkg::*;

  localparam int AW = $clog2(MAX_INNER);
  localparam int RW = $clog2(MAX_OUTER + 2);
  localparam logic [CNT_W-1:0] RST_OUTER_CNT = CNT_W'((MAX_OUTER < 640) ? MAX_OUTER : 640);
  localparam logic [CNT_W-1:0] RST_INNER_CNT = CNT_W'((MAX_INNER < 480) ? MAX_INNER : 480);

  function automatic logic [CNT_W-1:0] clamp_cnt(input logic [CNT_W-1:0] v, input int maxv);
    if (v == '0) return CNT_W'(1);
    if (32'(v) > 32'(maxv)) return CNT_W'(maxv);
    return v;
  endfunction

  // ---------------------------------------------------------------- state
  logic [CNT_W-1:0] outer_cnt_r, inner_cnt_r;
  logic [RW-1:0]    pos_r_r, pos_r_nxt;
  logic [AW-1:0]    pos_c_r, pos_c_nxt;

  logic             s1_v_r;
  pix_t             s1_px_r;
  logic [AW-1:0]    s1_col_r;
  logic             s1_in_frame_r;
  logic             s1_last_r;
  logic [3:0]       s1_edge_ok_r;  // top, bottom, left, right neighbor present
  logic [IDX_W-1:0] s1_cr_r, s1_cc_r;

  pix_t             win_r [WIN_N];
  pix_t             win_nxt [WIN_N];

  logic             out_valid_r;
  logic [IDX_W-1:0] out_outer_r, out_inner_r;
  pix_t             out_value_r;
  logic             out_peak_r, out_end_r;

  logic             in_acc, s1_adv, s1_wr;
  logic             cfg_restart;
  line_pair_t       rd_pair, wr_pair;

  // ---------------------------------------------------------------- handshake
  assign s1_adv   = !out_valid_r || !out_stall;
  assign in_stall = s1_v_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;
  assign s1_wr    = s1_v_r && s1_adv;

  // Only a write to a real register restarts the frame
  assign cfg_restart = cfg_we &&
                       ((cfg_index == REG_OUTER_COUNT) || (cfg_index == REG_INNER_COUNT));

  // ---------------------------------------------------------------- decide position
  logic [15:0] r16, c16, oc16, ic16, cr16, cc16;
  logic        acc_in_frame, acc_last;
  logic [3:0]  acc_edge_ok;

  always_comb begin
    r16  = 16'(pos_r_r);
    c16  = 16'(pos_c_r);
    oc16 = 16'(outer_cnt_r);
    ic16 = 16'(inner_cnt_r);
    if (c16 != 16'd0) begin
      acc_in_frame = (r16 >= 16'd1) && (r16 <= oc16);
      cr16 = r16 - 16'd1;
      cc16 = c16 - 16'd1;
    end else begin
      acc_in_frame = (r16 >= 16'd2) && (r16 <= oc16 + 16'd1);
      cr16 = r16 - 16'd2;
      cc16 = ic16 - 16'd1;
    end
    acc_edge_ok[3] = (cr16 >= 16'd1);
    acc_edge_ok[2] = (cr16 + 16'd1 < oc16);
    acc_edge_ok[1] = (cc16 >= 16'd1);
    acc_edge_ok[0] = (cc16 + 16'd1 < ic16);
    acc_last = acc_in_frame && (cr16 == oc16 - 16'd1) && (cc16 == ic16 - 16'd1);

    // advance arrival position, wrap at line end, restart after the final pixel
    if (c16 + 16'd1 >= ic16) begin
      pos_c_nxt = '0;
      pos_r_nxt = RW'(r16 + 16'd1);
    end else begin
      pos_c_nxt = AW'(c16 + 16'd1);
      pos_r_nxt = pos_r_r;
    end
    if (acc_last) begin
      pos_c_nxt = '0;
      pos_r_nxt = '0;
    end
  end

  // ---------------------------------------------------------------- config and position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outer_cnt_r <= RST_OUTER_CNT;
      inner_cnt_r <= RST_INNER_CNT;
      pos_r_r     <= '0;
      pos_c_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OUTER_COUNT: begin
          outer_cnt_r <= clamp_cnt(cfg_wdata, MAX_OUTER);
          pos_r_r     <= '0;
          pos_c_r     <= '0;
        end
        REG_INNER_COUNT: begin
          inner_cnt_r <= clamp_cnt(cfg_wdata, MAX_INNER);
          pos_r_r     <= '0;
          pos_c_r     <= '0;
        end
        default: begin
        end
      endcase
    end else if (in_acc) begin
      pos_r_r <= pos_r_nxt;
      pos_c_r <= pos_c_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 1 capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_px_r       <= in_response;
      s1_col_r      <= pos_c_r;
      s1_in_frame_r <= acc_in_frame;
      s1_last_r     <= acc_last;
      s1_edge_ok_r  <= acc_edge_ok;
      s1_cr_r       <= cr16[IDX_W-1:0];
      s1_cc_r       <= cc16[IDX_W-1:0];
    end
  end

  // ---------------------------------------------------------------- line store
  assign wr_pair.older = rd_pair.newer;
  assign wr_pair.newer = s1_px_r;

  lmx_line_mem #(
    .DEPTH (MAX_INNER)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (pos_c_r),
    .wr_en   (s1_wr),
    .wr_addr (s1_col_r),
    .wr_data (wr_pair),
    .rd_data (rd_pair)
  );

  // ---------------------------------------------------------------- window shift and compare
  logic [2:0] row_ok, col_ok;
  logic       peak, emit;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_nxt[k*3 + 0] = win_r[k*3 + 1];
      win_nxt[k*3 + 1] = win_r[k*3 + 2];
    end
    win_nxt[2] = rd_pair.older;
    win_nxt[5] = rd_pair.newer;
    win_nxt[8] = s1_px_r;

    row_ok = {s1_edge_ok_r[2], 1'b1, s1_edge_ok_r[3]};
    col_ok = {s1_edge_ok_r[0], 1'b1, s1_edge_ok_r[1]};
    peak   = 1'b1;
    for (int dr = 0; dr < 3; dr++) begin
      for (int dc = 0; dc < 3; dc++) begin
        if ((dr * 3 + dc) != WIN_CTR && row_ok[dr] && col_ok[dc] &&
            (win_nxt[dr * 3 + dc] > win_nxt[WIN_CTR])) begin
          peak = 1'b0;
        end
      end
    end
    emit = s1_in_frame_r && (peak || s1_last_r);
  end

  // Clear on a frame restart, advance on each stage 1 transfer
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_restart) begin
      for (int k = 0; k < WIN_N; k++) win_r[k] <= '0;
    end else if (s1_wr) begin
      for (int k = 0; k < WIN_N; k++) win_r[k] <= win_nxt[k];
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_v_r && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_wr && emit) begin
      out_outer_r <= s1_cr_r;
      out_inner_r <= s1_cc_r;
      out_value_r <= win_nxt[WIN_CTR];
      out_peak_r  <= peak;
      out_end_r   <= s1_last_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_outer_index = out_outer_r;
  assign out_inner_index = out_inner_r;
  assign out_value       = out_value_r;
  assign out_is_peak     = out_peak_r;
  assign out_frame_end   = out_end_r;

  // ---------------------------------------------------------------- assertions
  // in_is_pad does not steer sequencing: items are counted by position alone.

  a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_peak_r || out_end_r))
    else $error("result is neither a peak nor the frame end");

  a_col_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(pos_c_r) < 32'(inner_cnt_r)))
    else $error("arrival column beyond line length");

  a_s1_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_v_r)
    else $error("transferred item missing from stage 1");

endmodule

`default_nettype wire

FILE: design/lmx_line_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module lmx_line_mem #(
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic                clk,
  input  wire logic                rd_en,
  input  wire logic [AW-1:0]       rd_addr,
  input  wire logic                wr_en,
  input  wire logic [AW-1:0]       wr_addr,
  input  wire lmx_pkg::line_pair_t wr_data,
  output lmx_pkg::line_pair_t      rd_data
);
  import lmx_pkg::*;

  line_pair_t mem [DEPTH];

  // Write back the updated column
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; forward a same-cycle write to the same column
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

`default_nettype wire

FILE: sim/local_max_3x3_detector_tb.sv
`timescale 1ns / 1ps

module local_max_3x3_detector_tb;
  import lmx_pkg::*;

  localparam int MAX_PIXELS = 1024;
  localparam int MAX_LINES = 1024;
  localparam int RANDOM_ITEMS = 800;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 20;
  localparam int LONG_HOLD = 200;
  localparam longint TIMEOUT_NS = 64'd20_000_000;

  // register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam pix_t PIX_MIN = {1'b1, 31'b0};
  localparam pix_t PIX_MAX = {1'b0, {31{1'b1}}};

  typedef enum {FILL_RANDOM, FILL_LEVELS, FILL_FLAT, FILL_EXTREMES} fill_t;

  typedef struct {
    logic [IDX_W-1:0] outer_idx;
    logic [IDX_W-1:0] inner_idx;
    pix_t             value;
    logic             is_peak;
    logic             frame_end;
  } decided_px_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CNT_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  pix_t in_response = '0;
  logic in_is_pad = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [IDX_W-1:0] out_outer_index;
  logic [IDX_W-1:0] out_inner_index;
  pix_t out_value;
  logic out_is_peak;
  logic out_frame_end;

  // predictor state: line stores, window, arrival position, frame geometry
  pix_t line_older [MAX_PIXELS];
  pix_t line_newer [MAX_PIXELS];
  pix_t nbhd [WIN_N];
  int arr_line;
  int arr_pixel;
  int lines_cfg;
  int pixels_cfg;

  decided_px_t pending_peaks [$];
  int mismatches = 0;
  int items_sent = 0;
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_left = 0;
  pix_t flat_value;

  local_max_3x3_detector #(
    .MAX_INNER(MAX_PIXELS),
    .MAX_OUTER(MAX_LINES)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_response(in_response),
    .in_is_pad(in_is_pad),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_outer_index(out_outer_index),
    .out_inner_index(out_inner_index),
    .out_value(out_value),
    .out_is_peak(out_is_peak),
    .out_frame_end(out_frame_end)
  );

  always #10 clk = ~clk;

  function automatic int clamp_count(input logic [CNT_W-1:0] v, input int limit);
    if (v == 0) return 1;
    if (int'(v) > limit) return limit;
    return int'(v);
  endfunction

  // Apply a register write to the predictor; a valid write restarts the frame.
  function automatic void predict_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CNT_W-1:0] data);
    if (idx == REG_OUTER_COUNT) begin
      lines_cfg = clamp_count(data, MAX_LINES);
    end else if (idx == REG_INNER_COUNT) begin
      pixels_cfg = clamp_count(data, MAX_PIXELS);
    end else begin
      return;
    end
    arr_line = 0;
    arr_pixel = 0;
    foreach (nbhd[i]) nbhd[i] = '0;
  endfunction

  // Advance the window by one pixel and queue the decision it causes, if any.
  function automatic void predict_pixel(input pix_t px);
    int cur_line, cur_pix, ctr_line, ctr_pix, nl, np;
    bit peak, last;
    decided_px_t rec;
    cur_line = arr_line;
    cur_pix = arr_pixel;
    // shift the window left and load the new column (lines r-2, r-1, r)
    for (int k = 0; k < 3; k++) begin
      nbhd[k*3]   = nbhd[k*3+1];
      nbhd[k*3+1] = nbhd[k*3+2];
    end
    nbhd[2] = line_older[cur_pix];
    nbhd[5] = line_newer[cur_pix];
    nbhd[8] = px;
    line_older[cur_pix] = line_newer[cur_pix];
    line_newer[cur_pix] = px;
    // window center lags one line plus one pixel
    if (cur_pix >= 1) begin
      ctr_line = cur_line - 1;
      ctr_pix = cur_pix - 1;
    end else begin
      ctr_line = cur_line - 2;
      ctr_pix = pixels_cfg - 1;
    end
    cur_pix++;
    if (cur_pix >= pixels_cfg) begin
      cur_pix = 0;
      cur_line++;
    end
    arr_pixel = cur_pix;
    arr_line = cur_line & 'h7FF;
    if (ctr_line < 0 || ctr_line >= lines_cfg || ctr_pix < 0 || ctr_pix >= pixels_cfg)
      return;
    // any strictly greater in-frame neighbor suppresses the center
    peak = 1'b1;
    for (int dl = -1; dl <= 1; dl++) begin
      for (int dp = -1; dp <= 1; dp++) begin
        nl = ctr_line + dl;
        np = ctr_pix + dp;
        if ((dl != 0 || dp != 0) && nl >= 0 && nl < lines_cfg && np >= 0 &&
            np < pixels_cfg && nbhd[(dl + 1) * 3 + dp + 1] > nbhd[WIN_CTR])
          peak = 1'b0;
      end
    end
    last = (ctr_line == lines_cfg - 1) && (ctr_pix == pixels_cfg - 1);
    if (last) begin
      arr_line = 0;
      arr_pixel = 0;
    end
    if (!peak && !last) return;
    rec.outer_idx = IDX_W'(ctr_line);
    rec.inner_idx = IDX_W'(ctr_pix);
    rec.value = nbhd[WIN_CTR];
    rec.is_peak = peak;
    rec.frame_end = last;
    pending_peaks.push_back(rec);
  endfunction

  function automatic pix_t pick_response(input fill_t fill);
    case (fill)
      FILL_LEVELS: return pix_t'($urandom_range(3)) - 2;
      FILL_FLAT:   return flat_value;
      FILL_EXTREMES: begin
        case ($urandom_range(4))
          0: return PIX_MIN;
          1: return PIX_MAX;
          2: return '0;
          3: return -1;
          default: return 1;
        endcase
      end
      default: return pix_t'($urandom);
    endcase
  endfunction

  // Receiver: a long hold-off when requested, otherwise random stalls.
  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      out_stall <= 1'b1;
      hold_off_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Compare each transferred result with the oldest pending decision.
  always @(posedge clk) begin
    decided_px_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_peaks.size() == 0) begin
        $display("%0t: unexpected result, expected none, got line %0d pixel %0d value %0h",
                 $time, out_outer_index, out_inner_index, out_value);
        mismatches++;
      end else begin
        want = pending_peaks.pop_front();
        check_field("outer_index", want.outer_idx, out_outer_index);
        check_field("inner_index", want.inner_idx, out_inner_index);
        check_field("value", want.value, out_value);
        check_field("is_peak", want.is_peak, out_is_peak);
        check_field("frame_end", want.frame_end, out_frame_end);
      end
    end
  end

  task automatic set_idling(input int send_idle, input int recv_stall);
    sender_idle_pct = send_idle;
    recv_stall_pct = recv_stall;
  endtask

  // Offer one pixel, hold it until transferred, then predict.
  task automatic send_pixel(input pix_t resp, input logic pad);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_response <= resp;
    in_is_pad   <= pad;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_pixel(resp);
    items_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every decision has arrived and the pipe is quiet.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_peaks.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] data);
    cfg_index <= idx;
    cfg_wdata <= data;
    cfg_we    <= 1'b1;
    @(posedge clk);
    predict_reg_write(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // One full frame followed by the drain items; a few marks are flipped on purpose.
  task automatic send_frame(input fill_t fill);
    int pixels, pads;
    pixels = lines_cfg * pixels_cfg;
    pads = pixels_cfg + 1;
    flat_value = pix_t'($urandom);
    repeat (pixels) send_pixel(pick_response(fill), $urandom_range(19) == 0);
    repeat (pads) send_pixel(pix_t'($urandom), $urandom_range(9) != 0);
  endtask

  // Degenerate frames, signed extremes, marked pixel inside, unmarked drain item.
  task automatic test_directed();
    set_idling(0, 0);
    write_reg(REG_OUTER_COUNT, '0);
    write_reg(REG_INNER_COUNT, '0);
    send_pixel(PIX_MAX, 1'b0);
    send_pixel(PIX_MIN, 1'b1);
    send_pixel('0, 1'b1);
    send_pixel(PIX_MIN, 1'b1);
    send_pixel(-1, 1'b0);
    send_pixel(1, 1'b1);
    wait_drained();
    // 3x3 frame where only the lower right neighbor beats the center
    write_reg(REG_OUTER_COUNT, 11'd3);
    write_reg(REG_INNER_COUNT, 11'd3);
    send_pixel(-7, 1'b0);
    send_pixel(PIX_MIN, 1'b0);
    send_pixel(-1, 1'b0);
    send_pixel(0, 1'b0);
    send_pixel(6, 1'b0);
    send_pixel(2, 1'b1);
    send_pixel(5, 1'b0);
    send_pixel(4, 1'b0);
    send_pixel(7, 1'b0);
    send_pixel(PIX_MAX, 1'b1);
    send_pixel(PIX_MIN, 1'b0);
    send_pixel(3, 1'b1);
    send_pixel(-3, 1'b1);
    wait_drained();
  endtask

  // Counts written above range saturate; then a single line and a single column.
  task automatic test_line_extremes();
    set_idling(0, 0);
    write_reg(REG_OUTER_COUNT, 11'h7FF);
    write_reg(REG_INNER_COUNT, 11'h7FF);
    repeat (20) send_pixel(pix_t'($urandom), 1'b0);
    wait_drained();
    write_reg(REG_OUTER_COUNT, 11'd1);
    write_reg(REG_INNER_COUNT, 11'd40);
    send_frame(FILL_RANDOM);
    wait_drained();
    write_reg(REG_OUTER_COUNT, 11'd30);
    write_reg(REG_INNER_COUNT, 11'd1);
    send_frame(FILL_LEVELS);
    wait_drained();
  endtask

  // Spare indexes leave a frame running; a real write restarts it.
  task automatic test_restart();
    set_idling(30, 30);
    write_reg(REG_OUTER_COUNT, 11'd4);
    write_reg(REG_INNER_COUNT, 11'd5);
    repeat (13) send_pixel(pix_t'($urandom), 1'b0);
    wait_drained();
    write_reg(REG_SPARE_2, CNT_W'($urandom));
    write_reg(REG_SPARE_3, CNT_W'($urandom));
    repeat (7) send_pixel(pick_response(FILL_LEVELS), 1'b0);
    repeat (6) send_pixel(pix_t'($urandom), 1'b1);
    wait_drained();
    repeat (9) send_pixel(pix_t'($urandom), 1'b0);
    wait_drained();
    write_reg(REG_INNER_COUNT, 11'd3);
    send_frame(FILL_LEVELS);
    wait_drained();
    repeat (5) send_pixel(pix_t'($urandom), 1'b1);
    wait_drained();
    write_reg(REG_OUTER_COUNT, 11'd2);
    send_frame(FILL_RANDOM);
    wait_drained();
  endtask

  // Hold the result side off while a flat frame makes every pixel a peak.
  task automatic test_output_hold();
    set_idling(0, 0);
    write_reg(REG_OUTER_COUNT, 11'd4);
    write_reg(REG_INNER_COUNT, 11'd8);
    @(posedge clk);
    hold_off_left = LONG_HOLD;
    @(negedge clk);
    send_frame(FILL_FLAT);
    wait_drained();
  endtask

  // Mostly well-formed frames of random shape and content, some cut short.
  task automatic test_random_frames();
    int start_count, phase, lines, pixels;
    start_count = items_sent;
    while (items_sent - start_count < RANDOM_ITEMS) begin
      phase = (items_sent - start_count) * 4 / RANDOM_ITEMS;
      case (phase)
        0: set_idling(0, 0);
        1: set_idling(75, 0);
        2: set_idling(0, 75);
        default: set_idling(30, 30);
      endcase
      if ($urandom_range(2) == 0) begin
        lines = $urandom_range(0, 6);
        pixels = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        wait_drained();
        write_reg(REG_OUTER_COUNT, CNT_W'(lines));
        write_reg(REG_INNER_COUNT, CNT_W'(pixels));
      end
      if ($urandom_range(7) == 0) begin
        // broken frame: stop part way and restart by a register write
        repeat ($urandom_range(1, lines_cfg * pixels_cfg))
          send_pixel(pix_t'($urandom), $urandom_range(1));
        wait_drained();
        if ($urandom_range(1) == 0)
          write_reg(REG_OUTER_COUNT, CNT_W'($urandom_range(1, 6)));
        else
          write_reg(REG_INNER_COUNT, CNT_W'($urandom_range(1, 12)));
      end else begin
        send_frame(fill_t'($urandom_range(3)));
        if ($urandom_range(3) == 0) wait_drained();
      end
    end
    wait_drained();
  endtask

  initial begin
    lines_cfg = clamp_count(11'd640, MAX_LINES);
    pixels_cfg = clamp_count(11'd480, MAX_PIXELS);
    arr_line = 0;
    arr_pixel = 0;
    foreach (nbhd[i]) nbhd[i] = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_line_extremes();
    test_restart();
    test_output_hold();
    test_random_frames();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("== FAIL ==");
    $finish;
  end

endmodule
